@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/csem_pkg.sv @@
// ----------------------------------------------------------------------------
// csem_pkg
// types, codes and defaults shared by the semaphore wait queue
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;
    localparam int ID_MAX_BITS        = 16;

    localparam int CMD_BITS    = 3;
    localparam int PORT_ID_BITS = 8;
    localparam int COUNT_BITS  = 16;
    localparam int STATUS_BITS = 4;

    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX   = 16'sh7fff;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN   = 16'sh8000;
    localparam logic signed [COUNT_BITS-1:0] COUNT_RESET = 16'sd1;

    localparam logic [CMD_BITS-1:0] CMD_TAKE        = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_TRY_TAKE    = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_GIVE        = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_GIVE_ALL    = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CANCEL_WAIT = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_SET_COUNT   = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_GRANTED        = 4'd0;
    localparam logic [STATUS_BITS-1:0] ST_QUEUED         = 4'd1;
    localparam logic [STATUS_BITS-1:0] ST_BUSY           = 4'd2;
    localparam logic [STATUS_BITS-1:0] ST_WOKEN          = 4'd3;
    localparam logic [STATUS_BITS-1:0] ST_COUNT_RAISED   = 4'd4;
    localparam logic [STATUS_BITS-1:0] ST_CANCELLED      = 4'd5;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND      = 4'd6;
    localparam logic [STATUS_BITS-1:0] ST_COUNT_SET      = 4'd7;
    localparam logic [STATUS_BITS-1:0] ST_QUEUE_FULL     = 4'd8;
    localparam logic [STATUS_BITS-1:0] ST_NOTHING_TO_WAKE = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAKE,
        S_WAKE_ALL,
        S_SCAN,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]            command;
        logic [PORT_ID_BITS-1:0]        thread_id;
        logic signed [COUNT_BITS-1:0]   count_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]         status;
        logic [PORT_ID_BITS-1:0]        woken_thread;
        logic signed [COUNT_BITS-1:0]   count_after;
        logic                           last;
    } result_t;

    function automatic logic signed [COUNT_BITS-1:0] count_inc(
        input logic signed [COUNT_BITS-1:0] c
    );
        return (c == COUNT_MAX) ? c : c + 16'sd1;
    endfunction

endpackage

@@ design/csem_ram.sv @@
// ----------------------------------------------------------------------------
// csem_ram
// generic single-write, single-read ram with a registered read port
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/counting_semaphore_wait_queue.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// counting semaphore with a fifo of waiting thread ids kept in a ram
// ----------------------------------------------------------------------------
// a transaction is accepted at a rising edge with start high and busy low;
// request carries command, thread_id and count_value. each result appears
// on result for one cycle with strobe high; result.last marks the final
// result of a transaction. the receiver cannot stall, results are never
// held back.
// steps per transaction, with each result registered onto the outputs:
//   take, try_take, set_count, give with no waiter: a single result
//   give with a waiter: the head entry is read, then one woken result
//   give_all with n waiters: n results, one result per cycle
//   cancel_wait of entry i among n waiters: entries are scanned from the
//   head until the id is found, then the n - 1 - i later entries move
//   down one slot to close the gap; an absent id is reported once all n
//   entries are scanned. busy stays high throughout, so a cancel holds off
//   the next transaction until the cancel is done
// the waiter ram has a single read port, which returns one entry per
// cycle. the queue is a ring with head and tail pointers. reset sets the
// count to 1 and empties the queue at once; the ram needs no clearing
// pass, entries are read only after being written.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
    import csem_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     strobe,
    output result_t  result
);

    `include "assert_macros.svh"

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    state_t                        state_reg, state_next;
    logic signed [COUNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]           total_reg, total_next;
    logic [PTR_BITS-1:0]           head_reg, head_next;
    logic [PTR_BITS-1:0]           tail_reg, tail_next;
    logic [PTR_BITS-1:0]           scan_addr_reg, scan_addr_next;
    logic [CNT_BITS-1:0]           scan_idx_reg, scan_idx_next;
    logic [THREAD_ID_BITS-1:0]     tid_reg, tid_next;
    logic                          strobe_reg, strobe_next;
    result_t                       result_reg, result_next;

    logic                          wr_en;
    logic [PTR_BITS-1:0]           wr_addr;
    logic [THREAD_ID_BITS-1:0]     wr_data;
    logic [PTR_BITS-1:0]           rd_addr;
    logic [THREAD_ID_BITS-1:0]     rd_data;

    logic                          accept;
    logic                          wake_all_go;
    logic [ID_MAX_BITS-1:0]        id_wide;
    logic [THREAD_ID_BITS-1:0]     tid_in;
    logic                          found;
    logic                          scan_end;
    logic                          shift_end;
    logic signed [COUNT_BITS-1:0]  count_up;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    function automatic logic [PORT_ID_BITS-1:0] id_out(
        input logic [THREAD_ID_BITS-1:0] id
    );
        logic [ID_MAX_BITS-1:0] w;
        w = ID_MAX_BITS'(id);
        return w[PORT_ID_BITS-1:0];
    endfunction

    csem_ram #(
        .WIDTH(THREAD_ID_BITS),
        .DEPTH(QUEUE_DEPTH),
        .ADDR_BITS(PTR_BITS)
    ) u_waiters (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign wake_all_go = accept && (request.command == CMD_GIVE_ALL) && (total_reg != '0);
    assign id_wide     = ID_MAX_BITS'(request.thread_id);
    assign tid_in      = id_wide[THREAD_ID_BITS-1:0];
    assign found       = (rd_data == tid_reg);
    assign scan_end    = (scan_idx_reg == total_reg - 1'b1);
    assign shift_end   = (scan_idx_reg + 1'b1 == total_reg);
    assign count_up    = count_inc(count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && total_reg != '0)
                begin
                    if (request.command == CMD_GIVE)
                    begin
                        state_next = S_WAKE;
                    end
                    else if (request.command == CMD_GIVE_ALL)
                    begin
                        state_next = S_WAKE_ALL;
                    end
                    else if (request.command == CMD_CANCEL_WAIT)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_WAKE:
            begin
                state_next = S_IDLE;
            end
            S_WAKE_ALL:
            begin
                if (total_reg == CNT_BITS'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    state_next = scan_end ? S_IDLE : S_SHIFT;
                end
                else if (scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_addr_next = scan_addr_reg;
        scan_idx_next  = scan_idx_reg;
        tid_next       = tid_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = tid_in;
        rd_addr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tid_next = tid_in;
                    result_next.last = 1'b1;
                    result_next.woken_thread = '0;
                    unique case (request.command)
                        CMD_TAKE:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg >= 16'sd1)
                            begin
                                count_next = count_reg - 16'sd1;
                                result_next.status = ST_GRANTED;
                                result_next.woken_thread = id_out(tid_in);
                            end
                            else if (total_reg == CNT_FULL)
                            begin
                                result_next.status = ST_QUEUE_FULL;
                            end
                            else
                            begin
                                if (count_reg != COUNT_MIN)
                                begin
                                    count_next = count_reg - 16'sd1;
                                end
                                wr_en      = 1'b1;
                                tail_next  = ptr_inc(tail_reg);
                                total_next = total_reg + 1'b1;
                                result_next.status = ST_QUEUED;
                                result_next.woken_thread = id_out(tid_in);
                            end
                        end
                        CMD_TRY_TAKE:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg > 16'sd0)
                            begin
                                count_next = count_reg - 16'sd1;
                                result_next.status = ST_GRANTED;
                                result_next.woken_thread = id_out(tid_in);
                            end
                            else
                            begin
                                result_next.status = ST_BUSY;
                            end
                        end
                        CMD_GIVE:
                        begin
                            if (total_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                count_next  = count_up;
                                result_next.status = ST_COUNT_RAISED;
                            end
                        end
                        CMD_GIVE_ALL:
                        begin
                            if (total_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                result_next.status = ST_NOTHING_TO_WAKE;
                            end
                        end
                        CMD_CANCEL_WAIT:
                        begin
                            scan_addr_next = head_reg;
                            scan_idx_next  = '0;
                            if (total_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                result_next.status = ST_NOT_FOUND;
                            end
                        end
                        CMD_SET_COUNT:
                        begin
                            strobe_next = 1'b1;
                            count_next  = request.count_value;
                            result_next.status = ST_COUNT_SET;
                        end
                        default:
                        begin
                            result_next = result_reg;
                        end
                    endcase
                    result_next.count_after = count_next;
                end
            end
            S_WAKE, S_WAKE_ALL:
            begin
                // read of the following head is already under way
                rd_addr     = ptr_inc(head_reg);
                strobe_next = 1'b1;
                count_next  = count_up;
                head_next   = ptr_inc(head_reg);
                total_next  = total_reg - 1'b1;
                result_next.status       = ST_WOKEN;
                result_next.woken_thread = id_out(rd_data);
                result_next.count_after  = count_up;
                result_next.last = (state_reg == S_WAKE) || (total_reg == CNT_BITS'(1));
            end
            S_SCAN:
            begin
                rd_addr = ptr_inc(scan_addr_reg);
                if (found)
                begin
                    strobe_next = 1'b1;
                    count_next  = count_up;
                    total_next  = total_reg - 1'b1;
                    tail_next   = ptr_dec(tail_reg);
                    result_next.status       = ST_CANCELLED;
                    result_next.woken_thread = id_out(rd_data);
                    result_next.count_after  = count_up;
                    result_next.last         = 1'b1;
                end
                else if (scan_end)
                begin
                    strobe_next = 1'b1;
                    result_next.status       = ST_NOT_FOUND;
                    result_next.woken_thread = '0;
                    result_next.count_after  = count_reg;
                    result_next.last         = 1'b1;
                end
                else
                begin
                    scan_addr_next = ptr_inc(scan_addr_reg);
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // close the gap: entry after the hole moves down one slot
                wr_en          = 1'b1;
                wr_addr        = scan_addr_reg;
                wr_data        = rd_data;
                rd_addr        = ptr_inc(ptr_inc(scan_addr_reg));
                scan_addr_next = ptr_inc(scan_addr_reg);
                scan_idx_next  = scan_idx_reg + 1'b1;
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= COUNT_RESET;
            total_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        scan_idx_reg  <= scan_idx_next;
        tid_reg       <= tid_next;
        result_reg    <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `ASSERT_NEXT(a_give_all_walks, wake_all_go, busy, "give_all did not walk the queue")
    `ASSERT_HOLDS(a_more_results_busy, strobe && !result.last |-> busy, "extra result while idle")
    `ASSERT_HOLDS(a_empty_ring, total_reg == '0 |-> head_reg == tail_reg, "head and tail apart")
    `ASSERT_HOLDS(a_busy_has_waiters, busy |-> total_reg != '0, "queue walk with no waiters")

endmodule
